>>> design/m64_pkg.sv
// Shared types, constants and helper functions for the streaming MurmurHash64A block.
// No dependencies; front, queue, multiplier, back and top level import this package.
`default_nettype none

package m64_pkg;

  // Mixing constants of MurmurHash64A.
  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
  localparam int unsigned MIX_SHIFT = 47;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // How a word takes part in the hash.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PART,
    KIND_FULL
  } word_kind_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [63:0] word;
    word_kind_t  kind;
    logic        first;
    logic        last;
    logic [31:0] length;
  } q_entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Sequencer states of the back part.
  typedef enum logic [3:0] {
    B_IDLE,
    B_SEED,
    B_SEED_W,
    B_BODY,
    B_K1_W,
    B_K2_W,
    B_A_W,
    B_TAIL,
    B_F_W,
    B_OUT
  } back_state_t;

  // Passes of the shared multiplier.
  typedef enum logic [1:0] {
    STEP_LO,
    STEP_CROSS_A,
    STEP_CROSS_B
  } mul_step_t;

  // Request and response of the constant multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

  // Mask that keeps the valid low bytes of a partial word.
  function automatic logic [63:0] byte_mask(input logic [3:0] count);
    logic [63:0] m;
    unique case (count)
      4'd1:    m = 64'h0000_0000_0000_00ff;
      4'd2:    m = 64'h0000_0000_0000_ffff;
      4'd3:    m = 64'h0000_0000_00ff_ffff;
      4'd4:    m = 64'h0000_0000_ffff_ffff;
      4'd5:    m = 64'h0000_00ff_ffff_ffff;
      4'd6:    m = 64'h0000_ffff_ffff_ffff;
      4'd7:    m = 64'h00ff_ffff_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // Xor of a value with itself shifted right by the mixing shift.
  function automatic logic [63:0] xorshift(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

`default_nettype wire

>>> design/m64_in_if.sv
// Input channel of the hash block: one message word per item.
// No dependencies.
`default_nettype none

interface m64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        first;
  logic        last;
  logic [31:0] total_length;

  modport source (
    output valid, data_word, byte_count, first, last, total_length,
    input  ready
  );
  modport sink (
    input  valid, data_word, byte_count, first, last, total_length,
    output ready
  );
endinterface

`default_nettype wire

>>> design/m64_out_if.sv
// Output channel of the hash block: one finished hash per item.
// No dependencies.
`default_nettype none

interface m64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );
  modport sink (
    input  valid, hash_value,
    output ready
  );
endinterface

`default_nettype wire

>>> design/m64_front.sv
// Front part: accepts message items and classifies them for the queue.
// Depends on m64_pkg and m64_in_if.
`default_nettype none

module m64_front
  import m64_pkg::*;
(
  m64_in_if.sink    msg,
  input  q_status_t q_status,
  output logic      push,
  output q_entry_t  entry
);

  // Items are taken whenever the queue has room.
  assign msg.ready = !q_status.full;
  assign push      = msg.valid && !q_status.full;

  // Classify the word and drop the bytes above the byte count.
  always_comb begin
    entry.first  = msg.first;
    entry.last   = msg.last;
    entry.length = msg.total_length;
    if (msg.byte_count >= 4'd8) begin
      entry.kind = KIND_FULL;
      entry.word = msg.data_word;
    end else if (msg.byte_count == 4'd0) begin
      entry.kind = KIND_NONE;
      entry.word = '0;
    end else begin
      entry.kind = KIND_PART;
      entry.word = msg.data_word & byte_mask(msg.byte_count);
    end
  end

endmodule

`default_nettype wire

>>> design/m64_queue.sv
// Short queue of classified items between the front and the back part.
// Depends on m64_pkg.
`default_nettype none

module m64_queue
  import m64_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

`default_nettype wire

>>> design/m64_mul.sv
// Multiplier by the mixing constant, modulo 2^64, built from one 32x32 multiplier.
// Depends on m64_pkg.
`default_nettype none

module m64_mul
  import m64_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0] operand;
  logic [63:0] product;
  logic        busy;
  logic        done;
  mul_step_t   step;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] partial;

  // Low times low first, then the two cross terms into the upper half.
  always_comb begin
    unique case (step)
      STEP_LO: begin
        op_a = operand[31:0];
        op_b = MIX_MUL_LO;
      end
      STEP_CROSS_A: begin
        op_a = operand[31:0];
        op_b = MIX_MUL_HI;
      end
      default: begin
        op_a = operand[63:32];
        op_b = MIX_MUL_LO;
      end
    endcase
    partial = 64'(op_a) * 64'(op_b);
  end

  // Pass control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= STEP_LO;
    end else begin
      done <= busy && (step == STEP_CROSS_B);
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_LO;
      end else if (busy) begin
        unique case (step)
          STEP_LO:      step <= STEP_CROSS_A;
          STEP_CROSS_A: step <= STEP_CROSS_B;
          default: begin
            step <= STEP_LO;
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  // Operand and running product.
  always_ff @(posedge clk) begin
    if (req.start) begin
      operand <= req.operand;
    end
    if (busy) begin
      if (step == STEP_LO) begin
        product <= partial;
      end else begin
        product[63:32] <= product[63:32] + partial[31:0];
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = product;

  // A new product is never requested while one is in progress.
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("multiplier started while busy");

  // Done follows the last pass.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("multiplier done without a pass in progress");

  // The last pass frees the unit.
  a_last_pass_frees: assert property (@(posedge clk) disable iff (rst)
    (busy && step == STEP_CROSS_B && !req.start) |=> (!busy && done))
    else $error("multiplier did not finish after its last pass");

endmodule

`default_nettype wire

>>> design/m64_back.sv
// Back part: sequences seeding, word mixing and the final avalanche on the
// shared multiplier and holds the result item. Depends on m64_pkg and m64_out_if.
`default_nettype none

module m64_back
  import m64_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] seed,
  input  q_entry_t    head,
  input  q_status_t   q_status,
  output logic        pop,
  output mul_req_t    mul_req,
  input  mul_rsp_t    mul_rsp,
  m64_out_if.source   hash
);

  back_state_t state;
  back_state_t state_next;
  q_entry_t    cur;
  logic        cur_load;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic        out_load;
  logic        out_valid;
  logic [63:0] out_hash;

  // State, accumulator and the current item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      acc   <= '0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur <= head;
    end
  end

  // Sequencer.
  always_comb begin
    state_next      = state;
    acc_next        = acc;
    pop             = 1'b0;
    cur_load        = 1'b0;
    out_load        = 1'b0;
    mul_req.start   = 1'b0;
    mul_req.operand = '0;
    unique case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          cur_load   = 1'b1;
          state_next = head.first ? B_SEED : B_BODY;
        end
      end
      B_SEED: begin
        mul_req.start   = 1'b1;
        mul_req.operand = {32'd0, cur.length};
        state_next      = B_SEED_W;
      end
      B_SEED_W: begin
        if (mul_rsp.done) begin
          acc_next   = seed ^ mul_rsp.result;
          state_next = B_BODY;
        end
      end
      B_BODY: begin
        unique case (cur.kind)
          KIND_FULL: begin
            mul_req.start   = 1'b1;
            mul_req.operand = cur.word;
            state_next      = B_K1_W;
          end
          KIND_PART: begin
            mul_req.start   = 1'b1;
            mul_req.operand = acc ^ cur.word;
            state_next      = B_A_W;
          end
          default: begin
            state_next = B_TAIL;
          end
        endcase
      end
      B_K1_W: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = xorshift(mul_rsp.result);
          state_next      = B_K2_W;
        end
      end
      B_K2_W: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = acc ^ mul_rsp.result;
          state_next      = B_A_W;
        end
      end
      B_A_W: begin
        if (mul_rsp.done) begin
          acc_next   = mul_rsp.result;
          state_next = B_TAIL;
        end
      end
      B_TAIL: begin
        if (cur.last) begin
          mul_req.start   = 1'b1;
          mul_req.operand = xorshift(acc);
          state_next      = B_F_W;
        end else begin
          state_next = B_IDLE;
        end
      end
      B_F_W: begin
        if (mul_rsp.done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid || hash.ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Output register; the product stays in the multiplier until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hash <= xorshift(mul_rsp.result);
    end
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = out_hash;

endmodule

`default_nettype wire

>>> design/murmur64a_stream_hash.sv
// Top level of the streaming MurmurHash64A block: seed register, front, queue,
// back and the shared constant multiplier. Depends on these, m64_pkg and both interfaces.
//
// A message enters as little-endian 64-bit words on msg, the first item
// carrying the total byte length, and one 64-bit hash leaves on hash for each
// item marked last. The seed is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while the block is idle, which the block does not enforce.
// In the back part an item is seeded when it is first of a message, then mixed
// in with three multiplies for a full word or one for a partial one, and
// finalized with one more multiply when it is last; the single 32x32 multiplier
// needs three passes for each 64-bit multiply by the mixing constant. The front
// and the queue keep taking items while the back part works, up to the queue depth.
`default_nettype none

module murmur64a_stream_hash
  import m64_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  m64_in_if.sink      msg,
  m64_out_if.source   hash
);

  logic [63:0] seed;
  logic        push;
  logic        pop;
  q_entry_t    entry;
  q_entry_t    head;
  q_status_t   q_status;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  // Seed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_wr_en) begin
      seed <= cfg_wr_data;
    end
  end

  m64_front u_front (
    .msg      (msg),
    .q_status (q_status),
    .push     (push),
    .entry    (entry)
  );

  m64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .entry  (entry),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  m64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  m64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .seed     (seed),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .mul_req  (mul_req),
    .mul_rsp  (mul_rsp),
    .hash     (hash)
  );

endmodule

`default_nettype wire
